>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/clp_pkg.sv
package clp_pkg;

   localparam int CHAR_W     = 8;
   localparam int NUM_W      = 31;
   localparam int NUM_FIELDS = 7;
   localparam int KW_COUNT   = 5;
   localparam int KW_CHARS   = 15;

   localparam logic [2:0] KIND_INIT    = 3'd0;
   localparam logic [2:0] KIND_MOVE    = 3'd1;
   localparam logic [2:0] KIND_KNIGHT  = 3'd2;
   localparam logic [2:0] KIND_PEASANT = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;
   localparam logic [2:0] KIND_UNKNOWN = 3'd5;

   localparam logic [1:0] STATUS_LINE = 2'd0;
   localparam logic [1:0] STATUS_LONG = 2'd1;
   localparam logic [1:0] STATUS_EOI  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_NL   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SP   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_0    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9    = 8'h39;

   localparam logic [3:0] KW_POS_LAST = 4'd15;
   localparam logic [3:0] SLOT_OFFSET = 4'd3;
   localparam logic [NUM_W+3:0] NUM_MAX = 35'h07FFFFFFF;

   localparam logic [KW_CHARS*CHAR_W-1:0] KW_TEXT [KW_COUNT] = '{
      {"INIT", 88'h0},
      {"MOVE", 88'h0},
      {"PRODUCE_", "KNIGHT", 8'h0},
      {"PRODUCE_", "PEASANT"},
      {"END_", "TURN", 56'h0}
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd4, 4'd4, 4'd14, 4'd15, 4'd8};

   typedef enum logic [3:0] {
      PH_KEYWORD = 4'b0001,
      PH_NUMBER  = 4'b0010,
      PH_FAIL    = 4'b0100,
      PH_LONG    = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [1:0]                           status;
      logic [2:0]                           kind;
      logic                                 valid_res;
      logic [NUM_FIELDS-1:0][NUM_W-1:0]     numbers;
   } rsp_data_type;

   function automatic logic [KW_COUNT-1:0] kw_filter(
      input logic [KW_COUNT-1:0] cands,
      input logic [3:0]          pos,
      input logic [CHAR_W-1:0]   c
   );
      logic [KW_COUNT-1:0] keep;
      logic [3:0]          rpos;
      keep = cands;
      rpos = 4'd14 - pos;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (pos >= KW_LEN[k] || KW_TEXT[k][rpos*CHAR_W +: CHAR_W] != c) begin
            keep[k] = 1'b0;
         end
      end
      return keep;
   endfunction

   function automatic logic [2:0] kw_resolve(
      input logic [KW_COUNT-1:0] cands,
      input logic [3:0]          pos
   );
      logic [2:0] kind;
      kind = KIND_UNKNOWN;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (cands[k] && KW_LEN[k] == pos) begin
            kind = 3'(k);
         end
      end
      return kind;
   endfunction

   function automatic logic [3:0] kw_numbers(input logic [2:0] kind);
      logic [3:0] need;
      unique case (kind)
         KIND_INIT:                             need = 4'd7;
         KIND_MOVE, KIND_KNIGHT, KIND_PEASANT:  need = 4'd4;
         default:                               need = 4'd0;
      endcase
      return need;
   endfunction

endpackage

>>> rtl/clp_req_if.sv
interface clp_req_if;
   logic                            valid;
   logic                            ready;
   logic [clp_pkg::CHAR_W-1:0]      char_in;
   logic                            end_of_input;

   modport source (output valid, char_in, end_of_input, input ready);
   modport sink   (input valid, char_in, end_of_input, output ready);
endinterface

>>> rtl/clp_rsp_if.sv
interface clp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      status;
   logic [2:0]                      kind;
   logic                            valid_res;
   logic [clp_pkg::NUM_W-1:0]       board_size;
   logic [clp_pkg::NUM_W-1:0]       turn_number;
   logic [clp_pkg::NUM_W-1:0]       player;
   logic [clp_pkg::NUM_W-1:0]       from_x;
   logic [clp_pkg::NUM_W-1:0]       from_y;
   logic [clp_pkg::NUM_W-1:0]       to_x;
   logic [clp_pkg::NUM_W-1:0]       to_y;

   modport source (output valid, status, kind, valid_res, board_size, turn_number, player,
                   from_x, from_y, to_x, to_y, input ready);
   modport sink   (input valid, status, kind, valid_res, board_size, turn_number, player,
                   from_x, from_y, to_x, to_y, output ready);
endinterface

>>> rtl/command_line_parser.sv
// Command line parser.
// req_ch carries one text byte per transaction (char_in), or an end-of-input
// marker (end_of_input high, char_in ignored). rsp_ch carries one result per
// newline or end of input: status, kind, valid_res and seven 31-bit numbers
// (board_size, turn_number, player, from_x, from_y, to_x, to_y), zero where
// a number was not read.
// A byte is captured into an input register and parsed from there; any result
// of the byte that ends the line lands in the output register and drives rsp_ch.
// One byte is taken per cycle unless a result waits on an rsp_ch stall; the
// throughput is set by the single-pass parse step, one byte wide.
// When rsp_ch stalls, bytes that produce no result keep flowing; a byte that
// produces a result waits in the input register until the output register
// drains, and req_ch.ready drops while it waits.
// Lines of MAX_LINE bytes or more before their newline report status too long on it.
// Synchronous reset empties both registers and returns the parser to the
// start of a line.
`include "assert_macros.svh"

module command_line_parser #(
   parameter int MAX_LINE = 100
) (
   input  logic          clock,
   input  logic          reset,
   clp_req_if.sink       req_ch,
   clp_rsp_if.source     rsp_ch
);
   import clp_pkg::*;

   logic                    in_valid_ff;
   logic [CHAR_W-1:0]       in_char_ff;
   logic                    in_eoi_ff;
   logic                    out_valid_ff;
   rsp_data_type            out_data_ff;
   logic                    out_free;
   logic                    step_en;
   logic                    emit;
   rsp_data_type            result;

   clp_parser #(
      .MAX_LINE(MAX_LINE)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .char_in      (in_char_ff),
      .end_of_input (in_eoi_ff),
      .emit         (emit),
      .result       (result)
   );

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign step_en      = in_valid_ff && (!emit || out_free);
   assign req_ch.ready = !in_valid_ff || step_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         in_char_ff <= req_ch.char_in;
         in_eoi_ff  <= req_ch.end_of_input;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && emit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.status      = out_data_ff.status;
   assign rsp_ch.kind        = out_data_ff.kind;
   assign rsp_ch.valid_res   = out_data_ff.valid_res;
   assign rsp_ch.board_size  = out_data_ff.numbers[0];
   assign rsp_ch.turn_number = out_data_ff.numbers[1];
   assign rsp_ch.player      = out_data_ff.numbers[2];
   assign rsp_ch.from_x      = out_data_ff.numbers[3];
   assign rsp_ch.from_y      = out_data_ff.numbers[4];
   assign rsp_ch.to_x        = out_data_ff.numbers[5];
   assign rsp_ch.to_y        = out_data_ff.numbers[6];

   `ASSERT_NEXT(a_result_loaded, clock, reset, step_en && emit, out_valid_ff,
      "result not presented")
   `ASSERT_IMPLIES(a_stall_reason, clock, reset, in_valid_ff && !step_en,
      emit && out_valid_ff && !rsp_ch.ready, "input held without output stall")
   `ASSERT_IMPLIES(a_result_codes, clock, reset, out_valid_ff && out_data_ff.status != STATUS_LINE,
      out_data_ff.kind == KIND_UNKNOWN && !out_data_ff.valid_res, "data on non-line result")

endmodule

>>> rtl/clp_parser.sv
`include "assert_macros.svh"

module clp_parser #(
   parameter int MAX_LINE = 100
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [clp_pkg::CHAR_W-1:0]    char_in,
   input  logic                          end_of_input,
   output logic                          emit,
   output clp_pkg::rsp_data_type         result
);
   import clp_pkg::*;

   localparam int BC_W = $clog2(MAX_LINE + 1);

   logic [BC_W-1:0]                 byte_count_ff, byte_count_in;
   phase_type                       phase_ff, phase_in;
   logic [KW_COUNT-1:0]             cand_ff, cand_in;
   logic [3:0]                      kw_pos_ff, kw_pos_in;
   logic [2:0]                      kind_ff, kind_in;
   logic [2:0]                      tok_idx_ff, tok_idx_in;
   logic [NUM_W-1:0]                acc_ff, acc_in;
   logic                            line_ok_ff, line_ok_in;
   logic [NUM_FIELDS-1:0][NUM_W-1:0] fields_ff, fields_in;

   always_comb begin
      logic [2:0]       rk;
      logic [3:0]       need;
      logic [NUM_W+3:0] prod;
      logic [3:0]       slot;
      logic [3:0]       tok_next;
      logic             is_nl;
      logic             is_sp;
      logic             with_data;
      logic [1:0]       status;

      byte_count_in = byte_count_ff;
      phase_in      = phase_ff;
      cand_in       = cand_ff;
      kw_pos_in     = kw_pos_ff;
      kind_in       = kind_ff;
      tok_idx_in    = tok_idx_ff;
      acc_in        = acc_ff;
      line_ok_in    = line_ok_ff;
      fields_in     = fields_ff;
      emit          = 1'b0;
      with_data     = 1'b0;
      status        = STATUS_LINE;
      is_nl         = (char_in == CHAR_NL);
      is_sp         = (char_in == CHAR_SP);
      rk            = kw_resolve(cand_ff, kw_pos_ff);
      prod          = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                      + {31'd0, 4'(char_in - CHAR_0)};
      slot          = (kind_ff == KIND_INIT) ? {1'b0, tok_idx_ff}
                                             : {1'b0, tok_idx_ff} + SLOT_OFFSET;
      tok_next      = {1'b0, tok_idx_ff} + 4'd1;
      need          = kw_numbers(kind_ff);

      if (end_of_input) begin
         emit   = 1'b1;
         status = STATUS_EOI;
      end else if (phase_ff == PH_LONG) begin
         emit   = is_nl;
         status = STATUS_LONG;
      end else if (byte_count_ff >= BC_W'(MAX_LINE)) begin
         phase_in = PH_LONG;
         emit     = is_nl;
         status   = STATUS_LONG;
      end else begin
         byte_count_in = byte_count_ff + 1'b1;
         unique case (phase_ff)
            PH_KEYWORD: begin
               if (is_sp || is_nl) begin
                  kind_in = rk;
                  need    = kw_numbers(rk);
                  if (rk != KIND_UNKNOWN && is_sp && need != 4'd0) begin
                     phase_in = PH_NUMBER;
                  end else begin
                     if (rk == KIND_UNKNOWN || need != 4'd0 || is_sp) begin
                        line_ok_in = 1'b0;
                     end
                     if (is_nl) begin
                        emit      = 1'b1;
                        with_data = 1'b1;
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end
               end else if (char_in == CHAR_NUL) begin
                  phase_in   = PH_FAIL;
                  line_ok_in = 1'b0;
               end else if (kw_pos_ff == KW_POS_LAST) begin
                  cand_in = '0;
               end else begin
                  cand_in   = kw_filter(cand_ff, kw_pos_ff, char_in);
                  kw_pos_in = kw_pos_ff + 4'd1;
               end
            end
            PH_NUMBER: begin
               if (char_in >= CHAR_0 && char_in <= CHAR_9) begin
                  if (prod == '0 || prod > NUM_MAX) begin
                     phase_in   = PH_FAIL;
                     line_ok_in = 1'b0;
                  end else begin
                     acc_in = prod[NUM_W-1:0];
                  end
               end else if (is_sp || is_nl) begin
                  if (acc_ff != '0) begin
                     if (slot < 4'(NUM_FIELDS)) begin
                        fields_in[slot[2:0]] = acc_ff;
                     end
                     tok_idx_in = tok_next[2:0];
                     acc_in     = '0;
                  end
                  if (is_nl) begin
                     if (acc_ff == '0 || tok_next != need) begin
                        line_ok_in = 1'b0;
                     end
                     emit      = 1'b1;
                     with_data = 1'b1;
                  end else if (acc_ff == '0 || tok_next >= need) begin
                     phase_in   = PH_FAIL;
                     line_ok_in = 1'b0;
                  end
               end else begin
                  phase_in   = PH_FAIL;
                  line_ok_in = 1'b0;
               end
            end
            PH_FAIL: begin
               emit      = is_nl;
               with_data = 1'b1;
            end
            default: begin
               phase_in = PH_FAIL;
            end
         endcase
      end

      result.status    = status;
      result.kind      = with_data ? kind_in : KIND_UNKNOWN;
      result.valid_res = with_data & line_ok_in;
      result.numbers   = with_data ? fields_in : '0;

      if (emit) begin
         byte_count_in = '0;
         phase_in      = PH_KEYWORD;
         cand_in       = '1;
         kw_pos_in     = '0;
         kind_in       = KIND_UNKNOWN;
         tok_idx_in    = '0;
         acc_in        = '0;
         line_ok_in    = 1'b1;
         fields_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         phase_ff      <= PH_KEYWORD;
         cand_ff       <= '1;
         kw_pos_ff     <= '0;
         kind_ff       <= KIND_UNKNOWN;
         tok_idx_ff    <= '0;
         acc_ff        <= '0;
         line_ok_ff    <= 1'b1;
         fields_ff     <= '0;
      end else if (step_en) begin
         byte_count_ff <= byte_count_in;
         phase_ff      <= phase_in;
         cand_ff       <= cand_in;
         kw_pos_ff     <= kw_pos_in;
         kind_ff       <= kind_in;
         tok_idx_ff    <= tok_idx_in;
         acc_ff        <= acc_in;
         line_ok_ff    <= line_ok_in;
         fields_ff     <= fields_in;
      end
   end

   `ASSERT_NEXT(a_line_cleared, clock, reset, step_en && emit,
      byte_count_ff == '0 && phase_ff == PH_KEYWORD && line_ok_ff, "line state not cleared")
   `ASSERT_IMPLIES(a_number_kind, clock, reset, phase_ff == PH_NUMBER,
      kind_ff == KIND_INIT || kind_ff == KIND_MOVE || kind_ff == KIND_KNIGHT ||
      kind_ff == KIND_PEASANT, "number phase without numeric command")
   `ASSERT_IMPLIES(a_fail_not_ok, clock, reset, phase_ff == PH_FAIL, !line_ok_ff,
      "failed line still marked ok")

endmodule

>>> tb/sv/tb_command_line_parser.sv
module tb_command_line_parser;
   import clp_pkg::*;

   localparam int LINE_LIMIT  = 100;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint unsigned NUM_CEILING = 64'h7FFF_FFFF;

   logic clock;
   logic reset;

   clp_req_if req_ch ();
   clp_rsp_if rsp_ch ();

   command_line_parser #(.MAX_LINE(LINE_LIMIT)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   int unsigned     cycles;
   int unsigned     mismatches;
   int unsigned     sent_items;
   int unsigned     idle_pct;
   int unsigned     stall_pct;
   rsp_data_type    expected_lines [$];

   string num_names [NUM_FIELDS] = '{"board_size", "turn_number", "player",
                                     "from_x", "from_y", "to_x", "to_y"};

   // parser state mirror
   int unsigned     line_bytes;
   phase_type       scan_phase;
   logic [4:0]      kw_alive;
   int unsigned     kw_pos;
   logic [2:0]      line_kind;
   int unsigned     tok_count;
   longint unsigned num_acc;
   bit              line_good;
   logic [NUM_W-1:0] num_slot [NUM_FIELDS];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic string keyword_of(input logic [2:0] k);
      case (k)
         KIND_INIT:    return "INIT";
         KIND_MOVE:    return "MOVE";
         KIND_KNIGHT:  return $sformatf("%s_%s", "PRODUCE", "KNIGHT");
         KIND_PEASANT: return $sformatf("%s_%s", "PRODUCE", "PEASANT");
         KIND_END:     return $sformatf("%s_%s", "END", "TURN");
         default:      return "";
      endcase
   endfunction

   function automatic int numbers_for(input logic [2:0] k);
      case (k)
         KIND_INIT:                            return 7;
         KIND_MOVE, KIND_KNIGHT, KIND_PEASANT: return 4;
         default:                              return 0;
      endcase
   endfunction

   function automatic void clear_line();
      line_bytes = 0;
      scan_phase = PH_KEYWORD;
      kw_alive   = '1;
      kw_pos     = 0;
      line_kind  = KIND_UNKNOWN;
      tok_count  = 0;
      num_acc    = 0;
      line_good  = 1'b1;
      for (int j = 0; j < NUM_FIELDS; j++) num_slot[j] = '0;
   endfunction

   function automatic void drop_line();
      line_good  = 1'b0;
      scan_phase = PH_FAIL;
   endfunction

   function automatic void close_line(input logic [1:0] st, input bit with_data,
                                      output rsp_data_type res);
      res.status    = st;
      res.kind      = with_data ? line_kind : KIND_UNKNOWN;
      res.valid_res = with_data && line_good;
      for (int j = 0; j < NUM_FIELDS; j++) res.numbers[j] = with_data ? num_slot[j] : '0;
      clear_line();
   endfunction

   function automatic bit take_token();
      int unsigned slot;
      if (num_acc == 0) return 1'b0;
      slot = (line_kind == KIND_INIT) ? tok_count : tok_count + 3;
      if (slot < NUM_FIELDS) num_slot[slot] = num_acc[NUM_W-1:0];
      tok_count++;
      num_acc = 0;
      return 1'b1;
   endfunction

   function automatic bit parse_byte(input logic [7:0] c, input logic eoi,
                                     output rsp_data_type res);
      string           kw;
      int              need;
      longint unsigned v;
      res = '0;
      if (eoi) begin
         close_line(STATUS_EOI, 1'b0, res);
         return 1'b1;
      end
      if (scan_phase != PH_LONG && line_bytes >= LINE_LIMIT) scan_phase = PH_LONG;
      if (scan_phase == PH_LONG) begin
         if (c == CHAR_NL) begin
            close_line(STATUS_LONG, 1'b0, res);
            return 1'b1;
         end
         return 1'b0;
      end
      line_bytes++;
      case (scan_phase)
         PH_KEYWORD: begin
            if (c == CHAR_SP || c == CHAR_NL) begin
               line_kind = KIND_UNKNOWN;
               for (int k = 4; k >= 0; k--) begin
                  kw = keyword_of(3'(k));
                  if (kw_alive[k] && kw.len() == kw_pos) line_kind = 3'(k);
               end
               need = numbers_for(line_kind);
               if (line_kind == KIND_UNKNOWN) begin
                  line_good = 1'b0;
               end else if (c == CHAR_SP && need != 0) begin
                  scan_phase = PH_NUMBER;
                  return 1'b0;
               end else if (need != 0 || c == CHAR_SP) begin
                  line_good = 1'b0;
               end
               if (c == CHAR_NL) begin
                  close_line(STATUS_LINE, 1'b1, res);
                  return 1'b1;
               end
               drop_line();
               return 1'b0;
            end
            if (c == CHAR_NUL) begin
               drop_line();
               return 1'b0;
            end
            if (kw_pos >= 15) begin
               kw_alive = '0;
            end else begin
               for (int k = 0; k < 5; k++) begin
                  kw = keyword_of(3'(k));
                  if (kw_pos >= kw.len() || kw[kw_pos] != c) kw_alive[k] = 1'b0;
               end
               kw_pos++;
            end
            return 1'b0;
         end
         PH_NUMBER: begin
            need = numbers_for(line_kind);
            if (c >= CHAR_0 && c <= CHAR_9) begin
               v = num_acc * 10 + (c - CHAR_0);
               if (v == 0 || v > NUM_CEILING) drop_line();
               else num_acc = v;
               return 1'b0;
            end
            if (c == CHAR_SP) begin
               if (!take_token() || tok_count >= need) drop_line();
               return 1'b0;
            end
            if (c == CHAR_NL) begin
               if (!take_token() || tok_count != need) line_good = 1'b0;
               close_line(STATUS_LINE, 1'b1, res);
               return 1'b1;
            end
            drop_line();
            return 1'b0;
         end
         default: begin
            if (c == CHAR_NL) begin
               close_line(STATUS_LINE, 1'b1, res);
               return 1'b1;
            end
            return 1'b0;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR cycle %0d: %s", cycles, msg);
      mismatches++;
   endtask

   // hold valid until the transaction completes, then predict
   task automatic send_item(input logic [7:0] c, input logic eoi);
      rsp_data_type res;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid        = 1'b1;
      req_ch.char_in      = c;
      req_ch.end_of_input = eoi;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (parse_byte(c, eoi, res)) expected_lines.push_back(res);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      send_item(CHAR_NL, 1'b0);
   endtask

   task automatic send_fill(input int n, input logic [7:0] c);
      for (int i = 0; i < n; i++) send_item(c, 1'b0);
   endtask

   function automatic logic [7:0] random_text_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == CHAR_NL) ? 8'h41 : b;
   endfunction

   function automatic string random_number();
      int unsigned     r;
      longint unsigned v;
      r = $urandom_range(0, 99);
      if (r < 4) return "0";
      if (r < 8) return $sformatf("0%0d", $urandom_range(1, 999));
      if (r < 12) v = 64'd2147483648 + $urandom();
      else if (r < 16) v = NUM_CEILING - $urandom_range(0, 3);
      else if (r < 60) v = $urandom_range(1, 99);
      else if (r < 85) v = $urandom_range(1, 99999);
      else v = $urandom_range(1, 2147483647);
      return $sformatf("%0d", v);
   endfunction

   function automatic string random_word();
      string w;
      int    n;
      if ($urandom_range(0, 1) == 1) begin
         w = keyword_of(3'($urandom_range(0, 4)));
         n = $urandom_range(1, w.len());
         if ($urandom_range(0, 1) == 1) return w.substr(0, n - 1);
         return {w, "S"};
      end
      w = "";
      n = $urandom_range(1, 17);
      for (int i = 0; i < n; i++) w = $sformatf("%s%c", w, $urandom_range(65, 95));
      return w;
   endfunction

   task automatic random_line();
      string      line;
      logic [2:0] k;
      int         shape, n_num, bad_at, cut;
      logic [7:0] bad_val;
      shape = $urandom_range(0, 99);
      if (shape < 3) begin
         n_num = $urandom_range(LINE_LIMIT - 5, LINE_LIMIT + 30);
         for (int i = 0; i < n_num; i++) send_item(random_text_byte(), 1'b0);
         send_item(CHAR_NL, 1'b0);
         return;
      end
      if (shape < 8) begin
         n_num = $urandom_range(0, 20);
         for (int i = 0; i < n_num; i++) send_item(random_text_byte(), 1'b0);
         send_item(CHAR_NL, 1'b0);
         return;
      end
      k = 3'($urandom_range(0, 5));
      line  = (k == KIND_UNKNOWN) ? random_word() : keyword_of(k);
      n_num = (k == KIND_UNKNOWN) ? $urandom_range(0, 2) : numbers_for(k);
      if ($urandom_range(0, 9) == 0) n_num = n_num + $urandom_range(0, 2) - 1;
      for (int i = 0; i < n_num; i++) begin
         line = {line, ($urandom_range(0, 29) == 0) ? "  " : " ", random_number()};
      end
      if ($urandom_range(0, 29) == 0) line = {line, " "};
      bad_at  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, line.len() - 1) : -1;
      bad_val = 8'($urandom_range(0, 255));
      cut     = ($urandom_range(0, 49) == 0) ? $urandom_range(0, line.len()) : -1;
      for (int i = 0; i < line.len(); i++) begin
         if (i == cut) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
            return;
         end
         send_item((i == bad_at) ? bad_val : 8'(line[i]), 1'b0);
      end
      if (cut == line.len()) send_item(8'($urandom_range(0, 255)), 1'b1);
      else send_item(CHAR_NL, 1'b0);
   endtask

   task automatic test_valid_commands();
      send_line("INIT 1 2 3 4 5 6 7");
      send_line("MOVE 2147483647 1 2147483647 1");
      send_line({keyword_of(KIND_KNIGHT), " 5 6 7 8"});
      send_line({keyword_of(KIND_PEASANT), " 9 10 11 12"});
      send_line(keyword_of(KIND_END));
   endtask

   task automatic test_number_faults();
      send_line("MOVE 2147483648 1 1 1");
      send_line("MOVE 01 2 3 4");
      send_line("MOVE 0 2 3 4");
      send_line("MOVE 1  2 3 4");
      send_line("MOVE 1 2 3");
      send_line("INIT 1 2 3 4 5 6 7 8");
      send_line("MOVE 1 2 3 4 ");
      send_line("MOVE");
   endtask

   task automatic test_keyword_faults();
      send_line({keyword_of(KIND_END), " 3"});
      send_line("FOO 1");
      send_text("IN");
      send_item(CHAR_NUL, 1'b0);
      send_line("IT 1 2 3 4 5 6 7");
      send_text("MOVE 1 2");
      send_item(CHAR_NUL, 1'b0);
      send_line(" 3 4");
      send_item(8'hFF, 1'b0);
      send_line("move 1 2 3 4");
      send_line({keyword_of(KIND_PEASANT), "SS 1 2 3 4"});
      send_line("");
      send_line(" MOVE 1 2 3 4");
   endtask

   task automatic test_long_lines();
      send_fill(LINE_LIMIT - 1, 8'h41);
      send_item(CHAR_NL, 1'b0);
      send_fill(LINE_LIMIT, 8'h41);
      send_item(CHAR_NL, 1'b0);
      send_text("MOVE 1 2 3 4 ");
      send_fill(LINE_LIMIT + 20, 8'h37);
      send_item(CHAR_NL, 1'b0);
   endtask

   task automatic test_end_of_input();
      send_text("MOVE 1 2");
      send_item(8'h0A, 1'b1);
      send_item(8'hF5, 1'b1);
   endtask

   task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                      input int unsigned budget);
      int unsigned stop_at;
      idle_pct  = idle;
      stall_pct = stall;
      stop_at   = sent_items + budget;
      while (sent_items < stop_at) random_line();
   endtask

   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      rsp_data_type got, want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.status     = rsp_ch.status;
         got.kind       = rsp_ch.kind;
         got.valid_res  = rsp_ch.valid_res;
         got.numbers[0] = rsp_ch.board_size;
         got.numbers[1] = rsp_ch.turn_number;
         got.numbers[2] = rsp_ch.player;
         got.numbers[3] = rsp_ch.from_x;
         got.numbers[4] = rsp_ch.from_y;
         got.numbers[5] = rsp_ch.to_x;
         got.numbers[6] = rsp_ch.to_y;
         if (expected_lines.size() == 0) begin
            report_mismatch("result with none expected");
         end else begin
            want = expected_lines.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.kind !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.valid_res !== want.valid_res)
               report_mismatch($sformatf("valid_res %0b, want %0b",
                                         got.valid_res, want.valid_res));
            for (int j = 0; j < NUM_FIELDS; j++) begin
               if (got.numbers[j] !== want.numbers[j])
                  report_mismatch($sformatf("%s %0d, want %0d", num_names[j],
                                            got.numbers[j], want.numbers[j]));
            end
         end
      end
   end

   initial begin
      cycles              = 0;
      mismatches          = 0;
      sent_items          = 0;
      idle_pct            = 0;
      stall_pct           = 0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.char_in      = '0;
      req_ch.end_of_input = 1'b0;
      rsp_ch.ready        = 1'b0;
      clear_line();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_valid_commands();
      test_number_faults();
      test_keyword_faults();
      test_long_lines();
      test_end_of_input();
      test_random_traffic(0, 0, 170);
      test_random_traffic(66, 0, 170);
      test_random_traffic(0, 66, 170);
      test_random_traffic(13, 13, 170);

      req_ch.valid = 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
